@@ rtl/i2c_prs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_prs_pkg
// Types, codes and the register map of the I2C PMIC register target.
// ----------------------------------------------------------------------------
package i2c_prs_pkg;

  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned DRIVE_W  = 2;

  localparam logic [ADDR_W-1:0] DEV_ADDR_RESET = 7'd72;
  localparam logic [CNT_W-1:0]  BITS_PER_BYTE  = 4'd8;

  localparam logic [ACTION_W-1:0] ACT_BIT0  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BIT1  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd3;

  localparam logic [DRIVE_W-1:0] DRIVE_LOW   = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_HIGH  = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_FLOAT = 2'd2;

  localparam logic [BYTE_W-1:0] REG_03   = 8'd3;
  localparam logic [BYTE_W-1:0] REG_04   = 8'd4;
  localparam logic [BYTE_W-1:0] REG_07   = 8'd7;
  localparam logic [BYTE_W-1:0] REG_12   = 8'd12;
  localparam logic [BYTE_W-1:0] REG_13   = 8'd13;
  localparam logic [BYTE_W-1:0] REG_14   = 8'd14;
  localparam logic [BYTE_W-1:0] REG_GPIO = 8'd16;

  typedef enum logic [1:0] {
    PHASE_WAIT_ADDR = 2'd0,
    PHASE_RECEIVE   = 2'd1,
    PHASE_SEND      = 2'd2,
    PHASE_IDLE      = 2'd3
  } phase_t;

  function automatic logic [BYTE_W-1:0] reg_read(input logic [BYTE_W-1:0] idx,
                                                 input logic button);
    logic [BYTE_W-1:0] val;
    val = 8'h00;
    case (idx)
      REG_03, REG_04: val = 8'hFF;
      REG_07:         val = 8'h1B;
      REG_12:         val = 8'h72;
      REG_13:         val = 8'h68;
      REG_14:         val = 8'h88;
      REG_GPIO:       val = {7'd0, ~button};
      default:        val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

@@ rtl/i2c_pmic_register_slave.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_pmic_register_slave
// Bit-level I2C target: address match, register pointer load, read-back of a
// fixed register map with a power button GPIO bit.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// in        in_valid / in_stall (out)    action[1:0], power_button
// out       out_valid / out_stall (in)   bus_drive[1:0]
// cfg       cfg_wr_en                    cfg_wr_data[6:0] (device address)
//
// One item per cycle while in_stall is low; its result is registered in the
// output register or skid. Bus state updates in the same single pass.
// A two-entry output buffer (register plus skid) absorbs one stalled result;
// in_stall rises only when both entries are full.
// rst is synchronous, active high, and restores the device address to 72.
// ----------------------------------------------------------------------------
module i2c_pmic_register_slave (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [i2c_prs_pkg::ADDR_W-1:0]   cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [i2c_prs_pkg::ACTION_W-1:0] action,
  input  wire logic                             power_button,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [i2c_prs_pkg::DRIVE_W-1:0]       bus_drive
);

  logic [i2c_prs_pkg::ADDR_W-1:0]  device_address;
  logic [i2c_prs_pkg::BYTE_W-1:0]  shift_byte, shift_byte_next;
  logic [i2c_prs_pkg::CNT_W-1:0]   bits_left, bits_left_next;
  i2c_prs_pkg::phase_t             bus_phase, bus_phase_next;
  logic [i2c_prs_pkg::BYTE_W-1:0]  register_pointer, register_pointer_next;
  logic                            pointer_loaded, pointer_loaded_next;
  logic [i2c_prs_pkg::DRIVE_W-1:0] drive_next;
  logic [i2c_prs_pkg::DRIVE_W-1:0] skid_drive;
  logic                            skid_valid;
  logic                            in_acc, out_fire, data_evt;
  logic [i2c_prs_pkg::CNT_W-1:0]   bits_dec;
  logic [2:0]                      bit_sel;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;
  assign data_evt = (action == i2c_prs_pkg::ACT_BIT0 || action == i2c_prs_pkg::ACT_BIT1)
                    && bus_phase != i2c_prs_pkg::PHASE_IDLE;
  assign bits_dec = bits_left - 4'd1;
  assign bit_sel  = bits_dec[2:0];

  // next state
  always_comb begin
    shift_byte_next       = shift_byte;
    bits_left_next        = bits_left;
    bus_phase_next        = bus_phase;
    register_pointer_next = register_pointer;
    pointer_loaded_next   = pointer_loaded;
    if (action == i2c_prs_pkg::ACT_START) begin
      bus_phase_next = i2c_prs_pkg::PHASE_WAIT_ADDR;
      bits_left_next = i2c_prs_pkg::BITS_PER_BYTE;
    end else if (data_evt) begin
      if (bus_phase != i2c_prs_pkg::PHASE_SEND) begin
        shift_byte_next = {shift_byte[6:0], action[0]};
      end
      bits_left_next = bits_dec;
      if (bits_dec == '0) begin
        bits_left_next = i2c_prs_pkg::BITS_PER_BYTE;
        case (bus_phase)
          i2c_prs_pkg::PHASE_WAIT_ADDR: begin
            if (shift_byte_next[7:1] == device_address) begin
              if (shift_byte_next[0]) begin
                bus_phase_next  = i2c_prs_pkg::PHASE_SEND;
                shift_byte_next = i2c_prs_pkg::reg_read(register_pointer, power_button);
              end else begin
                bus_phase_next = i2c_prs_pkg::PHASE_RECEIVE;
              end
            end else begin
              bus_phase_next = i2c_prs_pkg::PHASE_IDLE;
            end
          end
          i2c_prs_pkg::PHASE_RECEIVE: begin
            if (pointer_loaded) begin
              pointer_loaded_next = 1'b0;
            end else begin
              register_pointer_next = shift_byte_next;
              pointer_loaded_next   = 1'b1;
            end
          end
          default: begin
            pointer_loaded_next = 1'b0;
          end
        endcase
      end
    end
  end

  // output
  always_comb begin
    drive_next = i2c_prs_pkg::DRIVE_FLOAT;
    if (data_evt && bus_phase == i2c_prs_pkg::PHASE_SEND) begin
      drive_next = shift_byte[bit_sel] ? i2c_prs_pkg::DRIVE_HIGH : i2c_prs_pkg::DRIVE_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= i2c_prs_pkg::DEV_ADDR_RESET;
      shift_byte       <= '0;
      bits_left        <= i2c_prs_pkg::BITS_PER_BYTE;
      bus_phase        <= i2c_prs_pkg::PHASE_WAIT_ADDR;
      register_pointer <= '0;
      pointer_loaded   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        device_address <= cfg_wr_data;
      end
      if (in_acc) begin
        shift_byte       <= shift_byte_next;
        bits_left        <= bits_left_next;
        bus_phase        <= bus_phase_next;
        register_pointer <= register_pointer_next;
        pointer_loaded   <= pointer_loaded_next;
      end
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        if (out_valid && !out_fire) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (out_valid && !out_fire) begin
        skid_drive <= drive_next;
      end else begin
        bus_drive <= drive_next;
      end
    end else if (out_fire && skid_valid) begin
      bus_drive <= skid_drive;
    end
  end

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    bits_left != 4'd0 && bits_left <= i2c_prs_pkg::BITS_PER_BYTE)
    else $error("bit count out of range");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while output register is empty");

  a_start_rearms: assert property (@(posedge clk) disable iff (rst)
    (in_acc && action == i2c_prs_pkg::ACT_START) |=>
      (bus_phase == i2c_prs_pkg::PHASE_WAIT_ADDR && bits_left == i2c_prs_pkg::BITS_PER_BYTE))
    else $error("start did not re-arm address matching");

  a_drive_only_send: assert property (@(posedge clk) disable iff (rst)
    (in_acc && bus_phase != i2c_prs_pkg::PHASE_SEND) |-> drive_next == i2c_prs_pkg::DRIVE_FLOAT)
    else $error("bus driven outside read phase");

endmodule
`default_nettype wire
